// ----- design/ctqm_pkg.sv -----
`timescale 1ns / 1ps

package ctqm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_LEN     = 8;
    localparam int HW_BUFFERS  = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int SLOT_W  = ID_W + LEN_W + DATA_W;

    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_TICK   = 3'd1;
    localparam logic [2:0] KIND_POLL   = 3'd2;
    localparam logic [2:0] KIND_START  = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;
    localparam logic [2:0] KIND_INIT   = 3'd5;
    localparam logic [2:0] KIND_DEINIT = 3'd6;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOT_OK = 2'd1;
    localparam logic [1:0] STATUS_BUSY   = 2'd2;

    localparam logic [1:0] MODE_UNINIT  = 2'd0;
    localparam logic [1:0] MODE_STOPPED = 2'd1;
    localparam logic [1:0] MODE_STARTED = 2'd2;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_STOP    = 2'd2;
    localparam logic [1:0] CMD_RECOVER = 2'd3;

    typedef logic [PTR_W-1:0] t_ptr;

    function automatic t_ptr ring_next(input t_ptr i);
        return (i == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : t_ptr'(i + 1'b1);
    endfunction

    function automatic t_ptr ring_count(input t_ptr head, input t_ptr tail);
        int diff;
        diff = int'(head) - int'(tail);
        if (diff < 0) begin
            diff = diff + QUEUE_DEPTH;
        end
        return t_ptr'(diff);
    endfunction

    function automatic logic [3:0] to_nibble(input t_ptr v);
        logic [PTR_W+3:0] wide;
        wide = {4'b0000, v};
        return wide[3:0];
    endfunction

    function automatic logic [DATA_W-1:0] mask_payload(input logic [DATA_W-1:0] data,
                                                       input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            if (LEN_W'(b) < len) begin
                res[8*b +: 8] = data[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ----- design/ctqm_ram.sv -----
`timescale 1ns / 1ps

module ctqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/can_tx_queue_mode_controller.sv -----
`timescale 1ns / 1ps

// CAN transmit front end: mode machine (uninit, stopped, started), bus-off latch and a
// software ring of QUEUE_DEPTH slots (one kept unused) held in a synchronous RAM. One input
// word is taken at a time. A word other than a transmit tick, or a tick that sends nothing,
// gives one result word in the cycle after it is taken. A tick that drains n queued
// frames gives n result words, each passing in order through S_READ (RAM read), S_EMIT
// (capture) and S_OUT (hand-off); an output stall holds S_OUT. The controller_id
// register may be written only while no word is in flight.
module can_tx_queue_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [28:0] i_frame_id,
    input  logic [3:0]  i_frame_len,
    input  logic [63:0] i_frame_data,
    input  logic [1:0]  i_hw_free,
    input  logic        i_hw_bus_off,
    input  logic        i_hw_ok,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_tx_valid,
    output logic [28:0] o_tx_id,
    output logic [3:0]  o_tx_len,
    output logic [63:0] o_tx_data,
    output logic        o_last,
    output logic [1:0]  o_mode,
    output logic        o_bus_off_event,
    output logic [7:0]  o_notify_controller,
    output logic [1:0]  o_hw_command,
    output logic [3:0]  o_queue_depth,
    output logic [3:0]  o_high_water
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [7:0]         r_ctrl_id;
    logic [1:0]         r_mode;
    logic               r_latch;
    ctqm_pkg::t_ptr     r_head;
    ctqm_pkg::t_ptr     r_tail;
    ctqm_pkg::t_ptr     r_peak;
    logic [1:0]         r_left;
    logic               r_out_valid;

    logic [1:0]         r_status;
    logic               r_tx_valid;
    logic [28:0]        r_tx_id;
    logic [3:0]         r_tx_len;
    logic [63:0]        r_tx_data;
    logic               r_last;
    logic [1:0]         r_mode_out;
    logic               r_event;
    logic [7:0]         r_notify;
    logic [1:0]         r_cmd;
    logic [3:0]         r_depth_out;
    logic [3:0]         r_hw_out;

    logic               in_acc;
    logic               out_acc;

    logic [1:0]         n_mode;
    logic               n_latch;
    ctqm_pkg::t_ptr     n_head;
    ctqm_pkg::t_ptr     n_tail;
    ctqm_pkg::t_ptr     n_peak;
    ctqm_pkg::t_ptr     n_depth;
    logic [1:0]         n_status;
    logic [1:0]         n_cmd;
    logic               n_event;
    logic               n_direct;
    logic               n_enq;
    logic [1:0]         n_send;

    ctqm_pkg::t_ptr     count;
    ctqm_pkg::t_ptr     head_nx;
    logic [1:0]         limit;
    logic [63:0]        masked;

    logic [ctqm_pkg::SLOT_W-1:0] ram_wdata;
    logic [ctqm_pkg::SLOT_W-1:0] ram_rdata;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign out_acc = r_out_valid && !i_out_stall;

    assign count   = ctqm_pkg::ring_count(r_head, r_tail);
    assign head_nx = ctqm_pkg::ring_next(r_head);
    assign masked  = ctqm_pkg::mask_payload(i_frame_data, i_frame_len);

    always_comb begin
        if (int'(i_hw_free) > ctqm_pkg::HW_BUFFERS) begin
            limit = 2'(ctqm_pkg::HW_BUFFERS);
        end else begin
            limit = i_hw_free;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_latch  = r_latch;
        n_head   = r_head;
        n_tail   = r_tail;
        n_peak   = r_peak;
        n_depth  = count;
        n_status = ctqm_pkg::STATUS_OK;
        n_cmd    = ctqm_pkg::CMD_NONE;
        n_event  = 1'b0;
        n_direct = 1'b0;
        n_enq    = 1'b0;
        n_send   = 2'd0;
        case (i_kind)
            ctqm_pkg::KIND_WRITE: begin
                if (r_mode != ctqm_pkg::MODE_STARTED
                        || int'(i_frame_len) > ctqm_pkg::MAX_LEN) begin
                    n_status = ctqm_pkg::STATUS_NOT_OK;
                end else if (i_hw_free != 2'd0) begin
                    n_direct = 1'b1;
                end else if (head_nx == r_tail) begin
                    n_status = ctqm_pkg::STATUS_BUSY;
                end else begin
                    n_enq   = 1'b1;
                    n_head  = head_nx;
                    n_depth = ctqm_pkg::t_ptr'(count + 1'b1);
                    if (n_depth > r_peak) begin
                        n_peak = n_depth;
                    end
                end
            end
            ctqm_pkg::KIND_TICK: begin
                if (r_mode == ctqm_pkg::MODE_STARTED) begin
                    if ({{ctqm_pkg::PTR_W{1'b0}}, limit} < {2'b00, count}) begin
                        n_send = limit;
                    end else begin
                        n_send = 2'(count);
                    end
                    n_depth = ctqm_pkg::t_ptr'(count - n_send);
                end
            end
            ctqm_pkg::KIND_POLL: begin
                if (r_mode == ctqm_pkg::MODE_STARTED) begin
                    if (i_hw_bus_off) begin
                        if (!r_latch) begin
                            n_latch = 1'b1;
                            n_event = 1'b1;
                        end
                    end else begin
                        n_latch = 1'b0;
                    end
                end
            end
            ctqm_pkg::KIND_START: begin
                if (r_mode == ctqm_pkg::MODE_STOPPED) begin
                    if (r_latch) begin
                        n_cmd = ctqm_pkg::CMD_RECOVER;
                        if (!i_hw_ok) begin
                            n_status = ctqm_pkg::STATUS_NOT_OK;
                        end else begin
                            n_latch = 1'b0;
                            n_mode  = ctqm_pkg::MODE_STARTED;
                        end
                    end else begin
                        n_cmd  = ctqm_pkg::CMD_START;
                        n_mode = ctqm_pkg::MODE_STARTED;
                    end
                end else begin
                    n_status = ctqm_pkg::STATUS_NOT_OK;
                end
            end
            ctqm_pkg::KIND_STOP: begin
                if (r_mode == ctqm_pkg::MODE_STARTED) begin
                    n_cmd  = ctqm_pkg::CMD_STOP;
                    n_mode = ctqm_pkg::MODE_STOPPED;
                end else begin
                    n_status = ctqm_pkg::STATUS_NOT_OK;
                end
            end
            ctqm_pkg::KIND_INIT: begin
                if (!i_hw_ok) begin
                    n_mode   = ctqm_pkg::MODE_UNINIT;
                    n_status = ctqm_pkg::STATUS_NOT_OK;
                end else begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_peak  = '0;
                    n_depth = '0;
                    n_latch = 1'b0;
                    n_mode  = ctqm_pkg::MODE_STOPPED;
                end
            end
            ctqm_pkg::KIND_DEINIT: begin
                n_cmd   = ctqm_pkg::CMD_STOP;
                n_mode  = ctqm_pkg::MODE_UNINIT;
                n_latch = 1'b0;
            end
            default: begin
                n_status = ctqm_pkg::STATUS_NOT_OK;
            end
        endcase
    end

    assign ram_wdata = {i_frame_id, i_frame_len, masked};

    ctqm_ram #(
        .WIDTH (ctqm_pkg::SLOT_W),
        .DEPTH (ctqm_pkg::QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (in_acc && n_enq),
        .i_waddr (r_head),
        .i_wdata (ram_wdata),
        .i_raddr (r_tail),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctrl_id   <= 8'd0;
            r_mode      <= ctqm_pkg::MODE_UNINIT;
            r_latch     <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_peak      <= '0;
            r_left      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ctrl_id <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode      <= n_mode;
                        r_latch     <= n_latch;
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_peak      <= n_peak;
                        r_left      <= n_send;
                        r_status    <= n_status;
                        r_cmd       <= n_cmd;
                        r_event     <= n_event;
                        r_notify    <= n_event ? r_ctrl_id : 8'd0;
                        r_mode_out  <= n_mode;
                        r_depth_out <= ctqm_pkg::to_nibble(n_depth);
                        r_hw_out    <= ctqm_pkg::to_nibble(n_peak);
                        r_tx_valid  <= n_direct;
                        r_tx_id     <= n_direct ? i_frame_id : 29'd0;
                        r_tx_len    <= n_direct ? i_frame_len : 4'd0;
                        r_tx_data   <= n_direct ? masked : 64'd0;
                        r_last      <= 1'b1;
                        if (n_send != 2'd0) begin
                            r_state <= S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_tx_valid  <= 1'b1;
                    r_tx_id     <= ram_rdata[ctqm_pkg::SLOT_W-1 -: ctqm_pkg::ID_W];
                    r_tx_len    <= ram_rdata[ctqm_pkg::DATA_W +: ctqm_pkg::LEN_W];
                    r_tx_data   <= ram_rdata[ctqm_pkg::DATA_W-1:0];
                    r_last      <= (r_left == 2'd1);
                    r_left      <= r_left - 2'd1;
                    r_tail      <= ctqm_pkg::ring_next(r_tail);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_state     <= (r_left != 2'd0) ? S_READ : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_tx_valid          = r_tx_valid;
    assign o_tx_id             = r_tx_id;
    assign o_tx_len            = r_tx_len;
    assign o_tx_data           = r_tx_data;
    assign o_last              = r_last;
    assign o_mode              = r_mode_out;
    assign o_bus_off_event     = r_event;
    assign o_notify_controller = r_notify;
    assign o_hw_command        = r_cmd;
    assign o_queue_depth       = r_depth_out;
    assign o_high_water        = r_hw_out;

endmodule
